// File: hdl/multi_channel_uart_ring_buffers_defines.svh
// Assertion macros shared by the UART ring buffer block.
`ifndef MULTI_CHANNEL_UART_RING_BUFFERS_DEFINES_SVH
`define MULTI_CHANNEL_UART_RING_BUFFERS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MCURB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MCURB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mcurb_pkg.sv
// Package: sizes, command codes and controller/datapath interface types.
`timescale 1ns / 1ps
package mcurb_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int RX_DEPTH     = 16;
    localparam int TX_DEPTH     = 16;

    // Field widths of a request and a result
    localparam int CMD_W   = 3;
    localparam int CHIN_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 24;

    // Derived widths
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RX_IW  = $clog2(RX_DEPTH);
    localparam int TX_IW  = $clog2(TX_DEPTH);
    localparam int TXF_W  = $clog2(TX_DEPTH + 1);
    localparam int RX_AW  = CH_W + RX_IW;
    localparam int TX_AW  = CH_W + TX_IW;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_RX = 3'd0,
        CMD_PUT_TX  = 3'd1,
        CMD_LINE_RX = 3'd2,
        CMD_TX_DONE = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_QUERY   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic rd;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_read;
    } t_dp_sts;

    // Pre-increment with wrap at the ring depth
    function automatic logic [RX_IW-1:0] rx_inc(input logic [RX_IW-1:0] idx);
        rx_inc = (idx == RX_IW'(RX_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [TX_IW-1:0] tx_inc(input logic [TX_IW-1:0] idx);
        tx_inc = (idx == TX_IW'(TX_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

// File: hdl/mcurb_ctrl.sv
// Controller: sequences capture, ring update, memory read and result hand-off.
`timescale 1ns / 1ps
module mcurb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output mcurb_pkg::t_dp_cmd o_cmd,
    input  mcurb_pkg::t_dp_sts i_sts
);
    import mcurb_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command outputs
    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
                if (i_req_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_read ? S_READ : S_RESP;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RESP;
            end
            S_RESP: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: hdl/mcurb_dp.sv
// Datapath: per-channel ring indices, ring memories and result registers.
`timescale 1ns / 1ps
module mcurb_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mcurb_pkg::IN_W-1:0]  i_req_data,
    output logic [mcurb_pkg::OUT_W-1:0] o_rsp_data,
    input  mcurb_pkg::t_dp_cmd         i_cmd,
    output mcurb_pkg::t_dp_sts         o_sts
);
    import mcurb_pkg::*;

    // Captured request
    logic [CMD_W-1:0]  r_cmd;
    logic [CHIN_W-1:0] r_ch;
    logic [BYTE_W-1:0] r_data;
    logic              r_ferr;
    logic              r_perr;

    // Per-channel ring state
    logic [RX_IW-1:0] r_rx_wi [NUM_CHANNELS];
    logic [RX_IW-1:0] r_rx_ri [NUM_CHANNELS];
    logic [TX_IW-1:0] r_tx_wi [NUM_CHANNELS];
    logic [TX_IW-1:0] r_tx_ri [NUM_CHANNELS];
    logic [TXF_W-1:0] r_tx_fill [NUM_CHANNELS];
    logic             r_tx_busy [NUM_CHANNELS];

    // Ring memories
    logic [BYTE_W-1:0] r_rx_mem [2**RX_AW];
    logic [BYTE_W-1:0] r_tx_mem [2**TX_AW];

    // Result registers
    logic              r_acc;
    logic              r_rx_read;
    logic              r_send_valid;
    logic              r_rx_empty;
    logic              r_ovf;
    logic              r_sending;
    logic              r_rd_tx;
    logic [RX_AW-1:0]  r_rd_rx_addr;
    logic [TX_AW-1:0]  r_rd_tx_addr;
    logic [BYTE_W-1:0] r_rdata;

    logic [CH_W-1:0]  chi;
    logic             ch_ok;
    logic [RX_IW-1:0] n_rx_wi;
    logic [RX_IW-1:0] n_rx_ri;
    logic [TX_IW-1:0] n_tx_wi;
    logic [TX_IW-1:0] n_tx_ri;
    logic [TXF_W-1:0] n_tx_fill;
    logic             n_tx_busy;
    logic             n_acc;
    logic             n_rx_read;
    logic             n_send_valid;
    logic             n_ovf;
    logic             rx_we;
    logic             tx_we;
    logic [RX_IW-1:0] rx_nxt;

    assign chi   = r_ch[CH_W-1:0];
    assign ch_ok = ({1'b0, r_ch} < (CHIN_W + 1)'(NUM_CHANNELS));

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_req_data[2:0];
            r_ch   <= i_req_data[5:3];
            r_data <= i_req_data[13:6];
            r_ferr <= i_req_data[14];
            r_perr <= i_req_data[15];
        end
    end

    // Command decode and ring update for the selected channel
    always_comb begin
        n_rx_wi      = r_rx_wi[chi];
        n_rx_ri      = r_rx_ri[chi];
        n_tx_wi      = r_tx_wi[chi];
        n_tx_ri      = r_tx_ri[chi];
        n_tx_fill    = r_tx_fill[chi];
        n_tx_busy    = r_tx_busy[chi];
        n_acc        = 1'b0;
        n_rx_read    = 1'b0;
        n_send_valid = 1'b0;
        n_ovf        = 1'b0;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rx_nxt       = rx_inc(r_rx_wi[chi]);
        unique case (r_cmd)
            CMD_READ_RX: begin
                if (n_rx_wi != n_rx_ri) begin
                    n_rx_ri   = rx_inc(n_rx_ri);
                    n_acc     = 1'b1;
                    n_rx_read = 1'b1;
                end
            end
            CMD_PUT_TX: begin
                if (n_tx_fill < TXF_W'(TX_DEPTH)) begin
                    n_tx_fill = n_tx_fill + 1'b1;
                    n_tx_wi   = tx_inc(n_tx_wi);
                    tx_we     = 1'b1;
                    n_acc     = 1'b1;
                end
                // Idle channel starts sending the head byte at once
                if (!n_tx_busy && (n_tx_fill != '0)) begin
                    n_tx_fill    = n_tx_fill - 1'b1;
                    n_tx_ri      = tx_inc(n_tx_ri);
                    n_send_valid = 1'b1;
                    n_tx_busy    = 1'b1;
                end
            end
            CMD_LINE_RX: begin
                if (!r_ferr && !r_perr) begin
                    if (rx_nxt == n_rx_ri) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_rx_wi = rx_nxt;
                        rx_we   = 1'b1;
                        n_acc   = 1'b1;
                    end
                end
            end
            CMD_TX_DONE: begin
                if (n_tx_fill != '0) begin
                    n_tx_fill    = n_tx_fill - 1'b1;
                    n_tx_ri      = tx_inc(n_tx_ri);
                    n_send_valid = 1'b1;
                    n_tx_busy    = 1'b1;
                end else begin
                    n_tx_busy = 1'b0;
                end
            end
            CMD_CLEAR: begin
                n_rx_wi   = '0;
                n_rx_ri   = '0;
                n_tx_wi   = '0;
                n_tx_ri   = '0;
                n_tx_fill = '0;
                n_tx_busy = 1'b0;
            end
            default: ;
        endcase
    end

    assign o_sts.need_read = ch_ok && (n_rx_read || n_send_valid);

    // Channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_rx_wi[i]   <= '0;
                r_rx_ri[i]   <= '0;
                r_tx_wi[i]   <= '0;
                r_tx_ri[i]   <= '0;
                r_tx_fill[i] <= '0;
                r_tx_busy[i] <= 1'b0;
            end
        end else if (i_cmd.exec && ch_ok) begin
            r_rx_wi[chi]   <= n_rx_wi;
            r_rx_ri[chi]   <= n_rx_ri;
            r_tx_wi[chi]   <= n_tx_wi;
            r_tx_ri[chi]   <= n_tx_ri;
            r_tx_fill[chi] <= n_tx_fill;
            r_tx_busy[chi] <= n_tx_busy;
        end
    end

    // Ring memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && ch_ok && rx_we) r_rx_mem[{chi, n_rx_wi}] <= r_data;
        if (i_cmd.exec && ch_ok && tx_we) r_tx_mem[{chi, n_tx_wi}] <= r_data;
    end

    // Ring memory read, in the cycle after the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_rd_tx ? r_tx_mem[r_rd_tx_addr] : r_rx_mem[r_rd_rx_addr];
        end
    end

    // Result fields; bad channel yields all zeros
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_acc        <= ch_ok && n_acc;
            r_rx_read    <= ch_ok && n_rx_read;
            r_send_valid <= ch_ok && n_send_valid;
            r_ovf        <= ch_ok && n_ovf;
            r_rx_empty   <= ch_ok && (n_rx_wi == n_rx_ri);
            r_sending    <= ch_ok && n_tx_busy;
            r_rd_tx      <= n_send_valid;
            r_rd_rx_addr <= {chi, n_rx_ri};
            r_rd_tx_addr <= {chi, n_tx_ri};
        end
    end

    // Pack the result
    always_comb begin
        o_rsp_data        = '0;
        o_rsp_data[0]     = r_acc;
        o_rsp_data[8:1]   = r_rx_read ? r_rdata : '0;
        o_rsp_data[9]     = r_send_valid;
        o_rsp_data[17:10] = r_send_valid ? r_rdata : '0;
        o_rsp_data[18]    = r_rx_empty;
        o_rsp_data[19]    = r_ovf;
        o_rsp_data[20]    = r_sending;
    end

endmodule

// File: hdl/multi_channel_uart_ring_buffers.sv
// Multi-channel UART receive/transmit ring buffers, one request at a time.
// Each request is captured, then the ring indices are updated, then a ring byte
// is read when one is returned, and the result is then held until it is taken;
// a new request is taken only after the result has been handed off.
// Reset: synchronous active-low; clears all ring indices, fill counts and
// busy flags; ring contents are undefined until written.
`timescale 1ns / 1ps
`include "multi_channel_uart_ring_buffers_defines.svh"
module multi_channel_uart_ring_buffers (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // command[2:0], channel[5:3], data[13:6], frame_error[14], parity_error[15]
    input  logic [mcurb_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // accepted[0], read_byte[8:1], send_valid[9], send_byte[17:10],
    // rx_is_empty[18], overflow[19], sending[20], zero[23:21]
    output logic [mcurb_pkg::OUT_W-1:0] m_axis_tdata
);
    import mcurb_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mcurb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    mcurb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_data (s_axis_tdata),
        .o_rsp_data (m_axis_tdata),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts)
    );

    // Checks
    `MCURB_ASSERT_NOW(a_one_in_flight, i_clk, i_rst_n, 1'b1, !(s_axis_tready && m_axis_tvalid), "request taken while result pending")
    `MCURB_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "request not held for execution")
    `MCURB_ASSERT_NOW(a_send_busy, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[9], m_axis_tdata[20], "byte sent on idle channel")
    `MCURB_ASSERT_NOW(a_ovf_drop, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[19], !m_axis_tdata[0], "overflow byte reported stored")

endmodule

// File: sim/mcurb_ring_checker.sv
// Checker for the UART ring buffer block: predicts each result and compares it.
`timescale 1ns / 1ps
module mcurb_ring_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_tvalid,
    input  logic                        i_req_tready,
    // command[2:0], channel[5:3], data[13:6], frame_error[14], parity_error[15]
    input  logic [mcurb_pkg::IN_W-1:0]  i_req_tdata,
    input  logic                        i_rsp_tvalid,
    input  logic                        i_rsp_tready,
    // accepted[0], read_byte[8:1], send_valid[9], send_byte[17:10],
    // rx_is_empty[18], overflow[19], sending[20], zero[23:21]
    input  logic [mcurb_pkg::OUT_W-1:0] i_rsp_tdata,
    output int                          o_pending,
    output int                          o_mismatches,
    output int                          o_checked,
    output int                          o_overflows,
    output int                          o_sends
);
    import mcurb_pkg::*;

    // Request fields, lowest bits last
    typedef struct packed {
        logic              parity_error;
        logic              frame_error;
        logic [BYTE_W-1:0] data;
        logic [CHIN_W-1:0] channel;
        logic [CMD_W-1:0]  command;
    } t_request;

    // Result fields, lowest bits last
    typedef struct packed {
        logic [OUT_W-22:0] pad;
        logic              sending;
        logic              overflow;
        logic              rx_is_empty;
        logic [BYTE_W-1:0] send_byte;
        logic              send_valid;
        logic [BYTE_W-1:0] read_byte;
        logic              accepted;
    } t_result;

    // Shadow copy of the per-channel rings
    logic [BYTE_W-1:0] rx_ring [NUM_CHANNELS][RX_DEPTH];
    logic [BYTE_W-1:0] tx_ring [NUM_CHANNELS][TX_DEPTH];
    int                rx_wr [NUM_CHANNELS];
    int                rx_rd [NUM_CHANNELS];
    int                tx_wr [NUM_CHANNELS];
    int                tx_rd [NUM_CHANNELS];
    int                tx_level [NUM_CHANNELS];
    bit                tx_active [NUM_CHANNELS];

    t_result           expected_results [$];
    int                mismatch_count;
    int                checked_count;
    int                overflow_count;
    int                send_count;

    function automatic int wrap_next(input int idx, input int depth);
        return (idx + 1 >= depth) ? 0 : idx + 1;
    endfunction

    // Pops the head of a channel's transmit ring
    function automatic logic [BYTE_W-1:0] take_tx_head(input int ch);
        tx_level[ch] = tx_level[ch] - 1;
        tx_rd[ch]    = wrap_next(tx_rd[ch], TX_DEPTH);
        return tx_ring[ch][tx_rd[ch]];
    endfunction

    // Applies one request to the shadow state and returns its result
    function automatic t_result predict_result(input t_request req);
        t_result r;
        int      ch;
        int      nxt;
        r  = '0;
        ch = int'(req.channel);
        if (ch >= NUM_CHANNELS)
            return r;
        case (req.command)
            CMD_READ_RX: begin
                if (rx_wr[ch] != rx_rd[ch]) begin
                    rx_rd[ch]   = wrap_next(rx_rd[ch], RX_DEPTH);
                    r.read_byte = rx_ring[ch][rx_rd[ch]];
                    r.accepted  = 1'b1;
                end
            end
            CMD_PUT_TX: begin
                if (tx_level[ch] < TX_DEPTH) begin
                    tx_level[ch] = tx_level[ch] + 1;
                    tx_wr[ch]    = wrap_next(tx_wr[ch], TX_DEPTH);
                    tx_ring[ch][tx_wr[ch]] = req.data;
                    r.accepted   = 1'b1;
                end
                // idle channel starts sending the head byte right away
                if (!tx_active[ch] && tx_level[ch] != 0) begin
                    r.send_byte   = take_tx_head(ch);
                    r.send_valid  = 1'b1;
                    tx_active[ch] = 1'b1;
                end
            end
            CMD_LINE_RX: begin
                if (!req.frame_error && !req.parity_error) begin
                    nxt = wrap_next(rx_wr[ch], RX_DEPTH);
                    if (nxt == rx_rd[ch]) begin
                        r.overflow = 1'b1;
                    end else begin
                        rx_wr[ch]         = nxt;
                        rx_ring[ch][nxt]  = req.data;
                        r.accepted        = 1'b1;
                    end
                end
            end
            CMD_TX_DONE: begin
                if (tx_level[ch] != 0) begin
                    r.send_byte   = take_tx_head(ch);
                    r.send_valid  = 1'b1;
                    tx_active[ch] = 1'b1;
                end else begin
                    tx_active[ch] = 1'b0;
                end
            end
            CMD_CLEAR: begin
                rx_wr[ch]     = 0;
                rx_rd[ch]     = 0;
                tx_wr[ch]     = 0;
                tx_rd[ch]     = 0;
                tx_level[ch]  = 0;
                tx_active[ch] = 1'b0;
            end
            default: ;
        endcase
        r.rx_is_empty = (rx_wr[ch] == rx_rd[ch]);
        r.sending     = tx_active[ch];
        return r;
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Monitor the request and result streams; results are compared before the new request is queued
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                rx_wr[c]     = 0;
                rx_rd[c]     = 0;
                tx_wr[c]     = 0;
                tx_rd[c]     = 0;
                tx_level[c]  = 0;
                tx_active[c] = 1'b0;
            end
            expected_results.delete();
            mismatch_count = 0;
            checked_count  = 0;
            overflow_count = 0;
            send_count     = 0;
        end else begin
            if (i_rsp_tvalid && i_rsp_tready) begin
                got = t_result'(i_rsp_tdata);
                if (expected_results.size() == 0) begin
                    $error("result 0x%0h arrived with no request outstanding", i_rsp_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", int'(want.accepted), int'(got.accepted));
                    check_field("read_byte", int'(want.read_byte), int'(got.read_byte));
                    check_field("send_valid", int'(want.send_valid), int'(got.send_valid));
                    check_field("send_byte", int'(want.send_byte), int'(got.send_byte));
                    check_field("rx_is_empty", int'(want.rx_is_empty),
                                int'(got.rx_is_empty));
                    check_field("overflow", int'(want.overflow), int'(got.overflow));
                    check_field("sending", int'(want.sending), int'(got.sending));
                    check_field("pad", int'(want.pad), int'(got.pad));
                    checked_count++;
                    if (want.overflow)
                        overflow_count++;
                    if (want.send_valid)
                        send_count++;
                end
            end
            if (i_req_tvalid && i_req_tready)
                expected_results.push_back(predict_result(t_request'(i_req_tdata)));
        end
        o_pending    <= expected_results.size();
        o_mismatches <= mismatch_count;
        o_checked    <= checked_count;
        o_overflows  <= overflow_count;
        o_sends      <= send_count;
    end

endmodule

// File: sim/multi_channel_uart_ring_buffers_tb.sv
// Testbench top: stimulus, result sink and verdict for the UART ring buffers.
`timescale 1ns / 1ps
module multi_channel_uart_ring_buffers_tb;
    import mcurb_pkg::*;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        MODE_RX_FILL,
        MODE_RX_DRAIN,
        MODE_TX_FILL,
        MODE_TX_DRAIN,
        MODE_MIXED
    } t_mode;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    // command[2:0], channel[5:3], data[13:6], frame_error[14], parity_error[15]
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    // accepted[0], read_byte[8:1], send_valid[9], send_byte[17:10],
    // rx_is_empty[18], overflow[19], sending[20], zero[23:21]
    logic [OUT_W-1:0] m_axis_tdata;

    int               pending;
    int               mismatches;
    int               checked;
    int               overflows;
    int               sends;
    int               request_count;
    int               cycle_count;
    bit               quiet;

    multi_channel_uart_ring_buffers dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mcurb_ring_checker ring_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_tvalid (s_axis_tvalid),
        .i_req_tready (s_axis_tready),
        .i_req_tdata  (s_axis_tdata),
        .i_rsp_tvalid (m_axis_tvalid),
        .i_rsp_tready (m_axis_tready),
        .i_rsp_tdata  (m_axis_tdata),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked),
        .o_overflows  (overflows),
        .o_sends      (sends)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multi_channel_uart_ring_buffers: mismatch");
            $finish;
        end
    end

    // Presents one request after a random gap, or none when quiet, and holds it until taken
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHIN_W-1:0] ch,
                                input logic [BYTE_W-1:0] data, input logic ferr,
                                input logic perr);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {perr, ferr, data, ch, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        request_count++;
    endtask

    // Stops sending and waits for every outstanding result
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Result sink: random stall after each accepted result, none when quiet
    initial begin : result_sink
        int hold;
        m_axis_tready = 1'b0;
        hold = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                hold = quiet ? 0 : $urandom_range(0, 5);
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        t_mode             mode;
        int                focus;
        int                burst;
        int                random_sent;
        int                roll;
        bit                paused;
        logic [CMD_W-1:0]  cmd;
        logic [CHIN_W-1:0] ch;
        logic [BYTE_W-1:0] data;
        logic              ferr;
        logic              perr;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cycle_count   = 0;
        request_count = 0;
        quiet         = 1'b0;
        random_sent   = 0;
        paused        = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty rings, immediate send, error drops, clear, bad channels, spare codes
        send_request(CMD_QUERY, 3'd0, 8'h00, 1'b0, 1'b0);
        send_request(CMD_READ_RX, 3'd0, 8'h00, 1'b0, 1'b0);
        send_request(CMD_TX_DONE, 3'd0, 8'h00, 1'b0, 1'b0);
        send_request(CMD_PUT_TX, 3'd0, 8'h00, 1'b0, 1'b0);
        send_request(CMD_PUT_TX, 3'd0, 8'hFF, 1'b1, 1'b1);
        send_request(CMD_TX_DONE, 3'd0, 8'h00, 1'b0, 1'b0);
        send_request(CMD_TX_DONE, 3'd0, 8'h00, 1'b0, 1'b0);
        send_request(CMD_LINE_RX, 3'd1, 8'hA5, 1'b1, 1'b0);
        send_request(CMD_LINE_RX, 3'd1, 8'h5A, 1'b0, 1'b1);
        send_request(CMD_LINE_RX, 3'd1, 8'hFF, 1'b1, 1'b1);
        send_request(CMD_LINE_RX, 3'd1, 8'hFF, 1'b0, 1'b0);
        send_request(CMD_LINE_RX, 3'd1, 8'h00, 1'b0, 1'b0);
        send_request(CMD_READ_RX, 3'd1, 8'h00, 1'b0, 1'b0);
        send_request(CMD_QUERY, 3'd1, 8'h00, 1'b0, 1'b0);
        send_request(CMD_PUT_TX, 3'd1, 8'h3C, 1'b0, 1'b0);
        send_request(CMD_CLEAR, 3'd1, 8'h00, 1'b0, 1'b0);
        send_request(CMD_READ_RX, 3'd1, 8'h00, 1'b0, 1'b0);
        send_request(CMD_PUT_TX, 3'd7, 8'hFF, 1'b1, 1'b1);
        send_request(CMD_LINE_RX, 3'd4, 8'h81, 1'b0, 1'b0);
        send_request(CMD_READ_RX, 3'd5, 8'h00, 1'b0, 1'b0);
        send_request(CMD_CLEAR, 3'd6, 8'h00, 1'b0, 1'b0);
        send_request(CMD_SPARE_A, 3'd2, 8'h00, 1'b0, 1'b0);
        send_request(CMD_SPARE_B, 3'd3, 8'hFF, 1'b1, 1'b1);
        send_request(CMD_PUT_TX, 3'd3, 8'h81, 1'b0, 1'b0);

        // Random bursts, each aimed at filling or draining one channel's ring, or mixed commands on any channel
        while (random_sent < RANDOM_ITEMS) begin
            mode  = t_mode'($urandom_range(0, 4));
            focus = $urandom_range(0, NUM_CHANNELS - 1);
            burst = $urandom_range(16, 48);
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst && random_sent < RANDOM_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                ch   = ($urandom_range(0, 9) == 0) ? CHIN_W'($urandom_range(0, 7)) :
                       CHIN_W'(focus);
                data = BYTE_W'($urandom_range(0, 255));
                ferr = ($urandom_range(0, 7) == 0);
                perr = ($urandom_range(0, 7) == 0);
                case (mode)
                    MODE_RX_FILL:
                        cmd = (roll < 78) ? CMD_LINE_RX : (roll < 88) ? CMD_READ_RX :
                              (roll < 98) ? CMD_QUERY : CMD_CLEAR;
                    MODE_RX_DRAIN:
                        cmd = (roll < 75) ? CMD_READ_RX : (roll < 90) ? CMD_LINE_RX :
                              (roll < 98) ? CMD_QUERY : CMD_CLEAR;
                    MODE_TX_FILL:
                        cmd = (roll < 75) ? CMD_PUT_TX : (roll < 90) ? CMD_TX_DONE :
                              (roll < 98) ? CMD_QUERY : CMD_CLEAR;
                    MODE_TX_DRAIN:
                        cmd = (roll < 70) ? CMD_TX_DONE : (roll < 90) ? CMD_PUT_TX :
                              (roll < 98) ? CMD_READ_RX : CMD_CLEAR;
                    default: begin
                        cmd = CMD_W'($urandom_range(0, 7));
                        ch  = CHIN_W'($urandom_range(0, 7));
                    end
                endcase
                send_request(cmd, ch, data, ferr, perr);
                random_sent++;
                if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
                    paused = 1'b1;
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests over %0d channels plus bad channel numbers and spare codes.",
                 request_count, NUM_CHANNELS);
        $display("Checked %0d results, %0d bytes handed to the transmitter, %0d rx overflows.",
                 checked, sends, overflows);
        if (mismatches == 0 && pending == 0) begin
            $display("multi_channel_uart_ring_buffers: match");
        end else begin
            $display("multi_channel_uart_ring_buffers: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mcurb_pkg.sv
hdl/mcurb_ctrl.sv
hdl/mcurb_dp.sv
hdl/multi_channel_uart_ring_buffers.sv
sim/mcurb_ring_checker.sv
sim/multi_channel_uart_ring_buffers_tb.sv
